// ----- hw/rtl/stepper_move_with_following_check_assert.svh -----
// assertion macros for the checker module
`ifndef STEPPER_MOVE_WITH_FOLLOWING_CHECK_ASSERT_SVH
`define STEPPER_MOVE_WITH_FOLLOWING_CHECK_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define STPM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define STPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/stpm_pkg.sv -----
`timescale 1ns / 1ps

package stpm_pkg;

  // pulse sequencer phases, one-hot
  typedef enum logic [8:0] {
    PH_IDLE     = 9'b000000001,
    PH_START    = 9'b000000010,
    PH_SET_ON   = 9'b000000100,
    PH_WAIT_ON  = 9'b000001000,
    PH_SET_OFF  = 9'b000010000,
    PH_WAIT_OFF = 9'b000100000,
    PH_CHECK    = 9'b001000000,
    PH_ERROR    = 9'b010000000,
    PH_DONE     = 9'b100000000
  } phase_t;

  // reported status codes
  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_DONE     = 3'd1,
    ST_ROT_ERR  = 3'd2,
    ST_BUSY     = 3'd3,
    ST_NOT_INIT = 3'd4
  } status_t;

  // configuration register indexes
  localparam logic [1:0] REG_START_PERIOD  = 2'd0;
  localparam logic [1:0] REG_TARGET_PERIOD = 2'd1;
  localparam logic [1:0] REG_MAX_ERROR     = 2'd2;
  localparam logic [1:0] REG_AXIS_READY    = 2'd3;

  // configuration reset values
  localparam logic [15:0] START_PERIOD_RST  = 16'd10;
  localparam logic [15:0] TARGET_PERIOD_RST = 16'd30;
  localparam logic [15:0] MAX_ERROR_RST     = 16'd10;

  typedef struct packed {
    logic [15:0] start_period;
    logic [15:0] target_period;
    logic [15:0] max_error;
    logic        axis_ready;
  } cfg_t;

  typedef struct packed {
    logic        step_pin;
    logic        dir_pin;
    logic        busy_res;
    status_t     status;
    logic [15:0] steps_remaining;
  } res_t;

endpackage

// ----- hw/rtl/stpm_fcheck.sv -----
`timescale 1ns / 1ps

module stpm_fcheck #(
  parameter int COORD_BITS = 16
) (
  input  logic [15:0] origin_coord,
  input  logic [15:0] encoder_count,
  input  logic        direction,
  input  logic [15:0] pulses_issued,
  input  logic [15:0] max_error,
  output logic        rot_err
);

  localparam int SUM_W = ((COORD_BITS > 16) ? COORD_BITS : 16) + 1;

  logic [31:0]           diff;
  logic [COORD_BITS-1:0] travel;
  logic [SUM_W-1:0]      limit;

  // encoder travel since origin, plus one, wrapped to the coordinate width
  always_comb begin
    if (direction) begin
      diff = {16'd0, origin_coord} - {16'd0, encoder_count} + 32'd1;
    end else begin
      diff = {16'd0, encoder_count} - {16'd0, origin_coord} + 32'd1;
    end
  end

  assign travel = diff[COORD_BITS-1:0];

  // more pulses than travel plus allowance is a following error
  assign limit   = SUM_W'(travel) + SUM_W'(max_error);
  assign rot_err = SUM_W'(pulses_issued) > limit;

endmodule

// ----- hw/rtl/stpm_core.sv -----
`timescale 1ns / 1ps

module stpm_core
  import stpm_pkg::*;
#(
  parameter int ACCEL_EVERY = 5,
  parameter int OFF_TICKS   = 3,
  parameter int COORD_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  cfg_t        cfg,
  input  logic        kind,
  input  logic [15:0] target_coord,
  input  logic [15:0] encoder_count,
  output res_t        res
);

  localparam int ACW = $clog2(ACCEL_EVERY + 1);

  phase_t         phase, phase_next;
  logic [15:0]    pulse_timer, pulse_timer_next;
  logic [15:0]    steps_left, steps_left_next;
  logic [15:0]    pulses_issued, pulses_issued_next;
  logic [15:0]    current_period, current_period_next;
  logic [15:0]    origin_coord, origin_coord_next;
  logic           direction, direction_next;
  logic           busy_flag, busy_flag_next;
  logic           step_level, step_level_next;
  logic [ACW-1:0] accel_cnt, accel_cnt_next;
  status_t        status;

  logic [15:0]    timer_dec;
  logic [ACW-1:0] accel_inc;
  logic           rot_err;

  // following-error compare for the check phase
  stpm_fcheck #(
    .COORD_BITS(COORD_BITS)
  ) u_fcheck (
    .origin_coord (origin_coord),
    .encoder_count(encoder_count),
    .direction    (direction),
    .pulses_issued(pulses_issued),
    .max_error    (cfg.max_error),
    .rot_err      (rot_err)
  );

  assign timer_dec = (pulse_timer != 16'd0) ? pulse_timer - 16'd1 : pulse_timer;
  assign accel_inc = accel_cnt + ACW'(1);

  // next state for one transaction
  always_comb begin
    phase_next          = phase;
    pulse_timer_next    = pulse_timer;
    steps_left_next     = steps_left;
    pulses_issued_next  = pulses_issued;
    current_period_next = current_period;
    origin_coord_next   = origin_coord;
    direction_next      = direction;
    busy_flag_next      = busy_flag;
    step_level_next     = step_level;
    accel_cnt_next      = accel_cnt;
    status              = ST_NONE;

    if (kind) begin
      // move command
      if (!cfg.axis_ready) begin
        status = ST_NOT_INIT;
      end else if (busy_flag) begin
        status = ST_BUSY;
      end else begin
        origin_coord_next = encoder_count;
        if (target_coord != encoder_count) begin
          if (target_coord > encoder_count) begin
            direction_next  = 1'b0;
            steps_left_next = target_coord - encoder_count;
          end else begin
            direction_next  = 1'b1;
            steps_left_next = encoder_count - target_coord;
          end
          current_period_next = cfg.start_period;
          phase_next          = PH_START;
        end
      end
    end else begin
      // time tick: timer counts down, then the sequencer takes one step
      pulse_timer_next = timer_dec;
      case (phase)
        PH_START: begin
          if (steps_left != 16'd0) begin
            busy_flag_next = 1'b1;
            phase_next     = PH_SET_ON;
          end else begin
            phase_next = PH_DONE;
          end
        end
        PH_SET_ON: begin
          pulse_timer_next   = current_period;
          step_level_next    = 1'b1;
          pulses_issued_next = pulses_issued + 16'd1;
          if (steps_left != 16'd0) begin
            steps_left_next = steps_left - 16'd1;
          end
          // accel_cnt tracks the issued pulse count modulo the ramp interval
          if (accel_inc == ACW'(ACCEL_EVERY)) begin
            accel_cnt_next = '0;
            if (current_period > cfg.target_period) begin
              current_period_next = current_period - 16'd1;
            end
          end else begin
            accel_cnt_next = accel_inc;
          end
          phase_next = PH_WAIT_ON;
        end
        PH_WAIT_ON: begin
          if (timer_dec == 16'd0) begin
            phase_next = PH_SET_OFF;
          end
        end
        PH_SET_OFF: begin
          pulse_timer_next = 16'(OFF_TICKS);
          step_level_next  = 1'b0;
          phase_next       = PH_WAIT_OFF;
        end
        PH_WAIT_OFF: begin
          if (timer_dec == 16'd0) begin
            phase_next = PH_CHECK;
          end
        end
        PH_CHECK: begin
          phase_next = rot_err ? PH_ERROR : PH_START;
        end
        PH_ERROR: begin
          status = ST_ROT_ERR;
        end
        PH_DONE: begin
          status             = ST_DONE;
          steps_left_next    = 16'd0;
          pulses_issued_next = 16'd0;
          accel_cnt_next     = '0;
          busy_flag_next     = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      pulse_timer    <= 16'd0;
      steps_left     <= 16'd0;
      pulses_issued  <= 16'd0;
      current_period <= 16'd0;
      origin_coord   <= 16'd0;
      direction      <= 1'b0;
      busy_flag      <= 1'b0;
      step_level     <= 1'b0;
      accel_cnt      <= '0;
    end else if (fire) begin
      phase          <= phase_next;
      pulse_timer    <= pulse_timer_next;
      steps_left     <= steps_left_next;
      pulses_issued  <= pulses_issued_next;
      current_period <= current_period_next;
      origin_coord   <= origin_coord_next;
      direction      <= direction_next;
      busy_flag      <= busy_flag_next;
      step_level     <= step_level_next;
      accel_cnt      <= accel_cnt_next;
    end
  end

  // result of this transaction
  assign res.step_pin        = step_level_next;
  assign res.dir_pin         = direction_next;
  assign res.busy_res        = busy_flag_next;
  assign res.status          = status;
  assign res.steps_remaining = steps_left_next;

endmodule

// ----- hw/rtl/stepper_move_with_following_check.sv -----
`timescale 1ns / 1ps

// One-axis stepper pulse generator with a period ramp and a following-error
// check against the encoder. Every input transaction is either a time tick or
// a move command, and each gives exactly one result transaction. The block
// takes one transaction per clock cycle while results are taken; a result is
// offered once its transaction has passed the input register and then the
// result register, and the axis state moves on as the transaction passes from
// one to the other. A full result register that is not taken holds the input
// register, after which in_ready drops. Configuration is written through
// cfg_wr_en / cfg_index / cfg_data and should only change while no transaction
// is in flight.
module stepper_move_with_following_check
  import stpm_pkg::*;
#(
  parameter int ACCEL_EVERY = 5,
  parameter int OFF_TICKS   = 3,
  parameter int COORD_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [15:0] target_coord,
  input  logic [15:0] encoder_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        step_pin,
  output logic        dir_pin,
  output logic        busy_res,
  output logic [2:0]  status,
  output logic [15:0] steps_remaining
);

  cfg_t        cfg;
  logic        s1_valid;
  logic        s1_kind;
  logic [15:0] s1_target;
  logic [15:0] s1_enc;
  logic        advance;
  res_t        core_res;
  res_t        res_q;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_period  <= START_PERIOD_RST;
      cfg.target_period <= TARGET_PERIOD_RST;
      cfg.max_error     <= MAX_ERROR_RST;
      cfg.axis_ready    <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_START_PERIOD:  cfg.start_period  <= cfg_data;
        REG_TARGET_PERIOD: cfg.target_period <= cfg_data;
        REG_MAX_ERROR:     cfg.max_error     <= cfg_data;
        REG_AXIS_READY:    cfg.axis_ready    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // handshake between input register and result register
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind   <= kind;
      s1_target <= target_coord;
      s1_enc    <= encoder_count;
    end
  end

  stpm_core #(
    .ACCEL_EVERY(ACCEL_EVERY),
    .OFF_TICKS  (OFF_TICKS),
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (advance),
    .cfg          (cfg),
    .kind         (s1_kind),
    .target_coord (s1_target),
    .encoder_count(s1_enc),
    .res          (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= core_res;
    end
  end

  assign step_pin        = res_q.step_pin;
  assign dir_pin         = res_q.dir_pin;
  assign busy_res        = res_q.busy_res;
  assign status          = res_q.status;
  assign steps_remaining = res_q.steps_remaining;

endmodule

// ----- hw/rtl/stpm_checker.sv -----
`timescale 1ns / 1ps

`include "stepper_move_with_following_check_assert.svh"

module stpm_checker
  import stpm_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        busy_res,
  input logic [2:0]  status,
  input logic [15:0] steps_remaining
);

  // a rejected move never clears the busy flag
  `STPM_ASSERT_IMPL(a_busy_reject, out_valid && status == ST_BUSY, busy_res, "busy reject while not busy")

  // a following error keeps the axis busy
  `STPM_ASSERT_IMPL(a_err_busy, out_valid && status == ST_ROT_ERR, busy_res, "rotation error while not busy")

  // a completed move has released the axis and has no steps left
  `STPM_ASSERT_IMPL(a_done_clear, out_valid && status == ST_DONE, !busy_res && steps_remaining == 16'd0, "complete with axis still held")

  // a stalled result transaction stays offered
  `STPM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

endmodule

bind stepper_move_with_following_check stpm_checker u_stpm_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .busy_res       (busy_res),
  .status         (status),
  .steps_remaining(steps_remaining)
);

// ----- sim/stepper_move_checker.sv -----
`timescale 1ns / 1ps

// watches both channels of the stepper axis, predicts every result transaction
// and compares it field by field with what the block returns
module stepper_move_checker
  import stpm_pkg::*;
#(
  parameter int ACCEL_EVERY = 5,
  parameter int OFF_TICKS   = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        kind,
  input  logic [15:0] target_coord,
  input  logic [15:0] encoder_count,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        step_pin,
  input  logic        dir_pin,
  input  logic        busy_res,
  input  logic [2:0]  status,
  input  logic [15:0] steps_remaining,
  output int          mismatches,
  output int          pending,
  output int          checked
);

  // shadow of the register file and of the axis state
  cfg_t        cfg;
  phase_t      ph;
  logic [15:0] pulse_tmr;
  logic [15:0] steps_left;
  logic [15:0] pulses_done;
  logic [15:0] period;
  logic [15:0] origin;
  logic        dir;
  logic        busy;
  logic        level;

  res_t        axis_results_q[$];
  res_t        want;

  // one tick or one move command applied to the shadow axis
  function automatic res_t axis_step(logic is_move, logic [15:0] tc, logic [15:0] enc);
    status_t     st;
    logic [15:0] travel;
    res_t        r;
    st = ST_NONE;
    if (is_move) begin
      if (!cfg.axis_ready) begin
        st = ST_NOT_INIT;
      end else if (busy) begin
        st = ST_BUSY;
      end else begin
        // origin is latched even when the target equals the current position
        origin = enc;
        if (tc != enc) begin
          dir        = (tc < enc);
          steps_left = dir ? enc - tc : tc - enc;
          period     = cfg.start_period;
          ph         = PH_START;
        end
      end
    end else begin
      if (pulse_tmr != 16'd0) pulse_tmr--;
      case (ph)
        PH_START: begin
          if (steps_left != 16'd0) begin
            busy = 1'b1;
            ph   = PH_SET_ON;
          end else begin
            ph = PH_DONE;
          end
        end
        PH_SET_ON: begin
          pulse_tmr = period;
          level     = 1'b1;
          pulses_done++;
          if (steps_left != 16'd0) steps_left--;
          // ramp: shorten the high time on every n-th pulse while above the target
          if (period > cfg.target_period && pulses_done % ACCEL_EVERY == 0) period--;
          ph = PH_WAIT_ON;
        end
        PH_WAIT_ON: begin
          if (pulse_tmr == 16'd0) ph = PH_SET_OFF;
        end
        PH_SET_OFF: begin
          pulse_tmr = 16'(OFF_TICKS);
          level     = 1'b0;
          ph        = PH_WAIT_OFF;
        end
        PH_WAIT_OFF: begin
          if (pulse_tmr == 16'd0) ph = PH_CHECK;
        end
        PH_CHECK: begin
          // encoder travel wraps at 16 bits, the comparison does not
          travel = dir ? origin - enc + 16'd1 : enc - origin + 16'd1;
          if (int'(pulses_done) > int'(travel) + int'(cfg.max_error)) ph = PH_ERROR;
          else ph = PH_START;
        end
        PH_ERROR: begin
          st = ST_ROT_ERR;
        end
        PH_DONE: begin
          st          = ST_DONE;
          steps_left  = 16'd0;
          pulses_done = 16'd0;
          busy        = 1'b0;
        end
        default: ;
      endcase
    end
    r.step_pin        = level;
    r.dir_pin         = dir;
    r.busy_res        = busy;
    r.status          = st;
    r.steps_remaining = steps_left;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // prediction on input transactions, comparison on result transactions
  always @(posedge clk) begin
    if (rst) begin
      cfg.start_period  = START_PERIOD_RST;
      cfg.target_period = TARGET_PERIOD_RST;
      cfg.max_error     = MAX_ERROR_RST;
      cfg.axis_ready    = 1'b0;
      ph          = PH_IDLE;
      pulse_tmr   = 16'd0;
      steps_left  = 16'd0;
      pulses_done = 16'd0;
      period      = 16'd0;
      origin      = 16'd0;
      dir         = 1'b0;
      busy        = 1'b0;
      level       = 1'b0;
      axis_results_q.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_START_PERIOD:  cfg.start_period  = cfg_data;
          REG_TARGET_PERIOD: cfg.target_period = cfg_data;
          REG_MAX_ERROR:     cfg.max_error     = cfg_data;
          REG_AXIS_READY:    cfg.axis_ready    = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        axis_results_q.push_back(axis_step(kind, target_coord, encoder_count));
      if (out_valid && out_ready) begin
        if (axis_results_q.size() == 0) begin
          $error("result transaction with no expectation waiting");
          mismatches++;
        end else begin
          want = axis_results_q.pop_front();
          check_field("step_pin", want.step_pin, step_pin);
          check_field("dir_pin", want.dir_pin, dir_pin);
          check_field("busy_res", want.busy_res, busy_res);
          check_field("status", want.status, status);
          check_field("steps_remaining", want.steps_remaining, steps_remaining);
          checked++;
        end
      end
    end
    pending <= axis_results_q.size();
  end

endmodule

// ----- sim/stepper_move_with_following_check_tb.sv -----
`timescale 1ns / 1ps

module stepper_move_with_following_check_tb;
  import stpm_pkg::*;

  localparam int ACCEL_EVERY = 5;
  localparam int OFF_TICKS   = 3;
  localparam int IDLE_LIMIT  = 1000;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        kind;
  logic [15:0] target_coord;
  logic [15:0] encoder_count;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        step_pin;
  logic        dir_pin;
  logic        busy_res;
  logic [2:0]  status;
  logic [15:0] steps_remaining;

  int mismatches;
  int pending;
  int checked;

  // stimulus bookkeeping
  int pos;
  int cur_period;
  int n_items;
  int n_moves;
  int n_ticks;
  int n_settings;
  int stall_left = 0;
  bit stall_on   = 1'b1;
  bit fast       = 1'b0;

  stepper_move_with_following_check #(
    .ACCEL_EVERY (ACCEL_EVERY),
    .OFF_TICKS   (OFF_TICKS),
    .COORD_BITS  (16)
  ) u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .target_coord    (target_coord),
    .encoder_count   (encoder_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .step_pin        (step_pin),
    .dir_pin         (dir_pin),
    .busy_res        (busy_res),
    .status          (status),
    .steps_remaining (steps_remaining)
  );

  stepper_move_checker #(
    .ACCEL_EVERY (ACCEL_EVERY),
    .OFF_TICKS   (OFF_TICKS)
  ) u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .target_coord    (target_coord),
    .encoder_count   (encoder_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .step_pin        (step_pin),
    .dir_pin         (dir_pin),
    .busy_res        (busy_res),
    .status          (status),
    .steps_remaining (steps_remaining),
    .mismatches      (mismatches),
    .pending         (pending),
    .checked         (checked)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (stall_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    out_ready <= (stall_left == 0);
  end

  // watchdog on cycles with no transaction on either channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // one input transaction, held until accepted
  task automatic send(input logic is_move, input logic [15:0] tc, input logic [15:0] enc);
    int   gap;
    logic rdy;
    gap = fast ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= is_move;
    target_coord  <= tc;
    encoder_count <= enc;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    n_items++;
    if (is_move) n_moves++;
    else n_ticks++;
  endtask

  task automatic tick_run(input int n, input logic [15:0] enc);
    repeat (n) send(1'b0, 16'($urandom), enc);
  endtask

  // hold the sender until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] sp, tp, me, rdy);
    drain();
    write_reg(REG_START_PERIOD, sp);
    write_reg(REG_TARGET_PERIOD, tp);
    write_reg(REG_MAX_ERROR, me);
    write_reg(REG_AXIS_READY, rdy);
    cfg_wr_en <= 1'b0;
    cur_period = sp;
    n_settings++;
  endtask

  // well-formed move: command from the current position, then enough ticks to
  // finish with the encoder reading the target; sometimes a rejected move inside
  task automatic clean_move(input int smax);
    int s;
    int tgt;
    int n;
    s = $urandom_range(1, smax);
    if (pos >= s && (pos + s > 65535 || $urandom_range(0, 1) == 1)) tgt = pos - s;
    else tgt = pos + s;
    n = s * (cur_period + 8) + 4 + $urandom_range(0, 3);
    send(1'b1, 16'(tgt), 16'(pos));
    pos = tgt;
    if ($urandom_range(0, 3) == 0) begin
      tick_run(2, 16'(tgt));
      send(1'b1, 16'($urandom), 16'($urandom));
      n -= 2;
    end
    tick_run(n, 16'(tgt));
  endtask

  // random encoder readings and short moves at any time
  task automatic noise_item(input int smax);
    logic [15:0] e;
    e = 16'($urandom);
    if ($urandom_range(0, 3) == 0) send(1'b1, e ^ 16'($urandom_range(0, smax)), e);
    else send(1'b0, 16'($urandom), e);
  endtask

  task automatic run_phase(input logic [15:0] sp, tp, me, rdy, input int smax,
                           input bit noisy, input int quota);
    int first;
    configure(sp, tp, me, rdy);
    fast     = ($urandom_range(0, 3) == 0);
    stall_on = ($urandom_range(0, 3) != 0);
    first    = n_items;
    while (n_items - first < quota) begin
      if (noisy && $urandom_range(0, 2) == 0) noise_item(smax);
      else clean_move(smax);
    end
    // noisy moves can differ from the encoder by up to smax
    if (noisy && rdy[0]) tick_run(2 * smax * (cur_period + 8) + 4, 16'($urandom));
  endtask

  // stimulus
  initial begin
    rst           <= 1'b1;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= REG_START_PERIOD;
    cfg_data      <= 16'd0;
    in_valid      <= 1'b0;
    kind          <= 1'b0;
    target_coord  <= 16'd0;
    encoder_count <= 16'd0;
    cur_period    = START_PERIOD_RST;
    n_items    = 0;
    n_moves    = 0;
    n_ticks    = 0;
    n_settings = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // axis not homed yet: moves refused, ticks idle
    send(1'b1, 16'hFFFF, 16'h0000);
    send(1'b1, 16'h0000, 16'hFFFF);
    send(1'b0, 16'h0000, 16'h0000);
    send(1'b0, 16'hFFFF, 16'hFFFF);

    // directed moves, axis ready written with upper data bits set
    configure(16'd3, 16'd1, 16'd0, 16'hFFFF);
    send(1'b1, 16'd100, 16'd100);
    send(1'b0, 16'd0, 16'd100);
    // second move overwrites the first while the sequencer is starting
    send(1'b1, 16'd102, 16'd100);
    send(1'b1, 16'd98, 16'd100);
    tick_run(2, 16'd98);
    send(1'b1, 16'd200, 16'd100);
    tick_run(2 * (3 + 8) + 2, 16'd98);
    // move to the same position while complete
    send(1'b1, 16'd98, 16'd98);
    send(1'b0, 16'd0, 16'd98);
    // coordinate extremes
    send(1'b1, 16'hFFFF, 16'hFFFD);
    tick_run(2 * (3 + 8) + 4, 16'hFFFF);
    send(1'b1, 16'h0000, 16'h0003);
    tick_run(3 * (3 + 8) + 4, 16'h0000);
    // long enough for the ramp to shorten the period once
    send(1'b1, 16'd6, 16'd0);
    tick_run(6 * (3 + 8) + 4, 16'd6);
    pos = 6;

    // random phases over several register settings
    run_phase(16'd1, 16'd1, 16'd0, 16'd1, 4, 1'b0, 40);
    run_phase(16'd6, 16'd2, 16'd3, 16'd1, 7, 1'b0, 60);
    run_phase(16'd0, 16'd65535, 16'd65535, 16'd1, 2, 1'b1, 30);
    run_phase(16'd5, 16'd65535, 16'd65535, 16'd0, 4, 1'b1, 30);
    run_phase(16'd2, 16'd1, 16'd2, 16'd1, 6, 1'b0, 50);
    run_phase(16'd4, 16'd3, 16'd65535, 16'd1, 2, 1'b1, 30);

    // one long pulse, sent back to back
    configure(16'd40, 16'd65535, 16'd65535, 16'd1);
    fast     = 1'b1;
    stall_on = 1'b0;
    send(1'b1, 16'd1001, 16'd1000);
    tick_run(40 + 8 + 4, 16'd1001);

    // encoder stuck at the origin: rotation error, which holds until reset
    configure(16'd1, 16'd1, 16'd0, 16'd1);
    fast     = 1'b0;
    stall_on = 1'b1;
    send(1'b1, 16'd503, 16'd500);
    tick_run(30, 16'd500);
    repeat (40) noise_item(15);

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d moves and %0d ticks over %0d register settings",
             n_moves, n_ticks, n_settings);
    $display("%0d results checked, ending with a long pulse and a rotation error", checked);
    if (mismatches == 0 && pending == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
